// ===== design/ntc_pkg.sv =====
// Package: shared constants, ROM table, status codes and controller/datapath command types
`default_nettype none
package ntc_pkg;
  localparam int TableEntries = 146;
  localparam int RomSize = 146;
  localparam int NEntries = (TableEntries > RomSize) ? RomSize :
                            ((TableEntries < 2) ? 2 : TableEntries);
  localparam int IdxW = $clog2(NEntries);
  localparam int RW = 23;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_COLD = 2'd1;
  localparam logic [1:0] STATUS_HOT  = 2'd2;

  localparam logic [1:0] REG_SUPPLY  = 2'd0;
  localparam logic [1:0] REG_DIVIDER = 2'd1;
  localparam logic [1:0] REG_UPPER   = 2'd2;

  localparam logic signed [14:0] ColdT = -15'sd4000;
  localparam logic signed [14:0] HotT = 15'(-4000 + 100 * (NEntries - 1));

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture the word and set up the divide
    logic div_step;   // one restoring step of the shared divider
    logic search_step;// compare one ROM entry
    logic frac_load;  // set up the fraction divide
    logic finish;     // form the result word
  } ntc_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic early;      // result known without any divide
    logic div_zero;   // division by zero
    logic found;      // bracket entry found
  } ntc_stat_t;

  function automatic logic [RW-1:0] rom(input logic [IdxW-1:0] i);
    logic [RW-1:0] r;
    unique case (i)
      0: r=5348390; 1: r=5006470; 2: r=4688538; 3: r=4392768; 4: r=4117490;
      5: r=3861166; 6: r=3622381; 7: r=3399835; 8: r=3192330; 9: r=2998763;
      10: r=2818120; 11: r=2649464; 12: r=2491930; 13: r=2344722; 14: r=2207106;
      15: r=2078400; 16: r=1957979; 17: r=1845264; 18: r=1739715; 19: r=1640840;
      20: r=1548178; 21: r=1461304; 22: r=1379824; 23: r=1303374; 24: r=1231616;
      25: r=1164234; 26: r=1100938; 27: r=1041458; 28: r=985542; 29: r=932958;
      30: r=883490; 31: r=836934; 32: r=793104; 33: r=751826; 34: r=712937;
      35: r=676286; 36: r=641731; 37: r=609143; 38: r=578397; 39: r=549381;
      40: r=521988; 41: r=496117; 42: r=471678; 43: r=448582; 44: r=426748;
      45: r=406102; 46: r=386572; 47: r=368091; 48: r=350599; 49: r=334037;
      50: r=318350; 51: r=303489; 52: r=289404; 53: r=276052; 54: r=263390;
      55: r=251380; 56: r=239984; 57: r=229168; 58: r=218900; 59: r=209148;
      60: r=199884; 61: r=191081; 62: r=182715; 63: r=174761; 64: r=167196;
      65: r=160000; 66: r=153153; 67: r=146636; 68: r=140432; 69: r=134523;
      70: r=128895; 71: r=123533; 72: r=118423; 73: r=113551; 74: r=108906;
      75: r=104476; 76: r=100249; 77: r=96216; 78: r=92367; 79: r=88692;
      80: r=85182; 81: r=81830; 82: r=78627; 83: r=75567; 84: r=72641;
      85: r=69844; 86: r=67170; 87: r=64611; 88: r=62164; 89: r=59821;
      90: r=57580; 91: r=55433; 92: r=53378; 93: r=51409; 94: r=49524;
      95: r=47716; 96: r=45984; 97: r=44324; 98: r=42732; 99: r=41205;
      100: r=39741; 101: r=38336; 102: r=36988; 103: r=35694; 104: r=34451;
      105: r=33258; 106: r=32113; 107: r=31012; 108: r=29955; 109: r=28939;
      110: r=27962; 111: r=27024; 112: r=26121; 113: r=25253; 114: r=24418;
      115: r=23615; 116: r=22842; 117: r=22098; 118: r=21382; 119: r=20693;
      120: r=20029; 121: r=19390; 122: r=18774; 123: r=18180; 124: r=17609;
      125: r=17058; 126: r=16527; 127: r=16015; 128: r=15521; 129: r=15045;
      130: r=14585; 131: r=14142; 132: r=13715; 133: r=13302; 134: r=12904;
      135: r=12519; 136: r=12148; 137: r=11790; 138: r=11443; 139: r=11109;
      140: r=10786; 141: r=10474; 142: r=10172; 143: r=9880; 144: r=9598;
      145: r=9325;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== design/ntc_if.sv =====
// Interfaces: input, output and configuration channels
`default_nettype none
interface ntc_in_if;
  logic valid;
  logic ready;
  logic [15:0] vadc_mv;
  modport source (output valid, output vadc_mv, input ready);
  modport sink (input valid, input vadc_mv, output ready);
endinterface

interface ntc_out_if;
  logic valid;
  logic ready;
  logic signed [14:0] temperature_centi_c;
  logic [1:0] range_status;
  modport source (output valid, output temperature_centi_c, output range_status, input ready);
  modport sink (input valid, input temperature_centi_c, input range_status, output ready);
endinterface

interface ntc_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [19:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/ntc_datapath.sv =====
// Datapath: divider resistance, ROM bracket search and interpolation
`default_nettype none
module ntc_datapath (
  input  wire logic               clk,
  input  wire ntc_pkg::ntc_cmd_t  cmd,
  output ntc_pkg::ntc_stat_t      stat,
  input  wire logic [15:0]        vadc_mv,
  input  wire logic [15:0]        supply_mv,
  input  wire logic [19:0]        divider_ohms,
  input  wire logic               ntc_is_upper,
  output logic signed [14:0]      temperature_centi_c,
  output logic [1:0]              range_status
);
  localparam int NumW = 56;  // 16*2^20*2^16 fits below 2^56
  localparam int DenW = 24;
  localparam logic [ntc_pkg::IdxW-1:0] LastIdx = ntc_pkg::IdxW'(ntc_pkg::NEntries - 1);
  localparam logic [ntc_pkg::IdxW-1:0] StopIdx = ntc_pkg::IdxW'(ntc_pkg::NEntries - 2);

  // shared restoring divider: dividend and quotient share one shift register
  logic [NumW-1:0] quo;
  logic [DenW:0]   rem;
  logic [DenW-1:0] den;
  logic [NumW-1:0] r16;
  logic [ntc_pkg::IdxW-1:0] k;
  logic [1:0] early_status;
  logic early;

  logic [15:0] diff;
  logic [39:0] prod;
  logic [DenW:0] trial;
  logic [ntc_pkg::RW-1:0] tk, tk1;
  logic [NumW-1:0] r_cmp;

  assign diff  = (supply_mv > vadc_mv) ? supply_mv - vadc_mv : 16'd0;
  assign prod  = {divider_ohms, 4'd0} * (ntc_is_upper ? diff : vadc_mv);
  assign trial = {rem[DenW-1:0], quo[NumW-1]};
  assign tk    = ntc_pkg::rom(k);
  assign tk1   = ntc_pkg::rom(k + 1'b1);
  // first compare takes the resistance straight from the divider
  assign r_cmp = (k == '0) ? quo : r16;

  assign stat.early    = early;
  assign stat.div_zero = (den == '0);
  assign stat.found    = (r_cmp >= NumW'(tk1)) || (k == StopIdx);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= NumW'(prod);
      rem <= '0;
      den <= ntc_is_upper ? DenW'(vadc_mv) : DenW'(diff);
      k   <= '0;
      early <= ntc_is_upper ? (vadc_mv == 16'd0) : (vadc_mv >= supply_mv);
      early_status <= ntc_pkg::STATUS_COLD;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NumW-2:0], 1'b0};
      end
    end else if (cmd.search_step) begin
      if (k == '0) begin
        r16 <= quo;
      end
      if (!(r_cmp >= NumW'(tk1)) && k != StopIdx)
        k <= k + 1'b1;
    end else if (cmd.frac_load) begin
      // numerator 200*(T[k]-R)+den, divisor 2*den
      quo <= NumW'(200 * (NumW'(tk) - r16) + NumW'(tk - tk1));
      rem <= '0;
      den <= DenW'({tk - tk1, 1'b0});
    end else if (cmd.finish) begin
      if (early) begin
        temperature_centi_c <= ntc_pkg::ColdT;
        range_status <= early_status;
      end else if (r16 > NumW'(ntc_pkg::rom('0))) begin
        temperature_centi_c <= ntc_pkg::ColdT;
        range_status <= ntc_pkg::STATUS_COLD;
      end else if (r16 < NumW'(ntc_pkg::rom(LastIdx))) begin
        temperature_centi_c <= ntc_pkg::HotT;
        range_status <= ntc_pkg::STATUS_HOT;
      end else begin
        temperature_centi_c <= 15'(-4000 + 100 * int'(k)) + 15'(quo[7:0]);
        range_status <= ntc_pkg::STATUS_OK;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/ntc_ctrl.sv =====
// Controller: sequences load, divides, search and result handshake
`default_nettype none
module ntc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ntc_pkg::ntc_cmd_t      cmd,
  input  wire ntc_pkg::ntc_stat_t stat
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SEARCH, S_FRAC, S_FDIV, S_FIN, S_OUT} state_t;
  state_t state;
  logic [5:0] cnt;

  assign in_ready = (state == S_IDLE);
  always_comb begin
    cmd = '0;
    cmd.load        = in_fire;
    cmd.div_step    = (state == S_DIV) || (state == S_FDIV);
    cmd.search_step = (state == S_SEARCH);
    cmd.frac_load   = (state == S_FRAC);
    cmd.finish      = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) begin
          state <= S_DIV;
          cnt <= '0;
        end
        S_DIV: begin
          if (stat.early || stat.div_zero) state <= S_FIN;
          else if (cnt == 6'd55) state <= S_SEARCH;
          cnt <= cnt + 6'd1;
        end
        S_SEARCH: if (stat.found) state <= S_FRAC;
        S_FRAC: begin
          state <= S_FDIV;
          cnt <= '0;
        end
        S_FDIV: begin
          if (cnt == 6'd55) state <= S_FIN;
          cnt <= cnt + 6'd1;
        end
        S_FIN: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          state <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/ntc_divider_temperature_lookup.sv =====
// Top level: configuration registers, controller and datapath
// channel   dir   payload
// cfg       in    index[1:0], data[19:0]
// in        in    vadc_mv[15:0]
// out       out   temperature_centi_c[14:0], range_status[1:0]
// One word in flight. When the voltage alone decides (zero, or at/above supply as the
// mode gives), out valid rises after the divide state and the finish state; otherwise
// after 56 resistance divide steps, 1 to 145 ROM compares, a fraction set-up, 56 fraction
// divide steps and a finish step; the bit-serial divider and linear search set the delay.
// in ready is high only while idle, so a held result stalls the input, and the
// controller returns to idle after each result. Synchronous reset restores defaults.
`default_nettype none
module ntc_divider_temperature_lookup (
  input wire logic clk,
  input wire logic rst,
  ntc_cfg_if.sink  cfg,
  ntc_in_if.sink   in_ch,
  ntc_out_if.source out_ch
);
  logic [15:0] supply_mv;
  logic [19:0] divider_ohms;
  logic ntc_is_upper;
  ntc_pkg::ntc_cmd_t cmd;
  ntc_pkg::ntc_stat_t stat;
  logic in_fire;

  assign cfg.ready = 1'b1;
  assign in_fire = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      supply_mv <= 16'd3000;
      divider_ohms <= 20'd10000;
      ntc_is_upper <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == ntc_pkg::REG_SUPPLY) supply_mv <= cfg.data[15:0];
      else if (cfg.index == ntc_pkg::REG_DIVIDER) divider_ohms <= cfg.data;
      else if (cfg.index == ntc_pkg::REG_UPPER) ntc_is_upper <= cfg.data[0];
    end
  end

  ntc_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd, .stat
  );

  ntc_datapath u_dp (
    .clk, .cmd, .stat, .vadc_mv(in_ch.vadc_mv), .supply_mv, .divider_ohms,
    .ntc_is_upper, .temperature_centi_c(out_ch.temperature_centi_c),
    .range_status(out_ch.range_status)
  );
endmodule
`default_nettype wire
